// File: rtl/ubfp_pkg.sv
// package for the ultrasonic bcd frame parser: frame constants, sync state type
// and the bcd range arithmetic; no dependencies
`default_nettype none

package ubfp_pkg;

  localparam int unsigned NumChannels = 12;
  localparam int unsigned ChanW       = 4;
  localparam int unsigned RangeW      = 15;
  localparam int unsigned CountW      = 4;

  localparam logic [7:0] SyncByte    = 8'hAA;
  localparam logic [7:0] LenByte     = 8'h08;
  localparam logic [7:0] TypeByte    = 8'h06;
  localparam logic [7:0] GroupLoByte = 8'h11;
  localparam logic [7:0] GroupMiByte = 8'h12;

  localparam logic [3:0] PosSync  = 4'd0;
  localparam logic [3:0] PosLen   = 4'd3;
  localparam logic [3:0] PosType  = 4'd6;
  localparam logic [3:0] PosGroup = 4'd7;
  localparam logic [3:0] PosFirst = 4'd1;
  localparam logic [3:0] PosLast  = 4'd15;

  localparam logic [1:0] GroupLo = 2'd0;
  localparam logic [1:0] GroupMi = 2'd1;
  localparam logic [1:0] GroupHi = 2'd2;

  localparam logic [CountW-1:0] FpuReset = 4'd3;

  typedef enum logic [1:0] {
    SYNC_HUNT   = 2'd0,
    SYNC_FIRST  = 2'd1,
    SYNC_STEADY = 2'd2
  } sync_mode_e;

  typedef logic [RangeW-1:0] range_t;

  // nibbles above nine are kept as they are, so the result reaches 165
  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return 8'((hi << 3) + (hi << 1) + lo);
  endfunction

  // dec(high) * 100 + dec(low), at most 16665
  function automatic range_t range_calc(input logic [7:0] hi_b, input logic [7:0] lo_b);
    range_t h;
    range_t l;
    h = range_t'(bcd_dec(hi_b));
    l = range_t'(bcd_dec(lo_b));
    return range_t'((h << 6) + (h << 5) + (h << 2) + l);
  endfunction

endpackage

`default_nettype wire

// File: rtl/ultrasonic_bcd_frame_parser_core.sv
// ultrasonic bcd frame parser: byte stream in, bursts of twelve channel ranges out
// depends on ubfp_pkg
`default_nettype none

// usage
//   in channel  : in_valid_i / in_ready_o with rx_byte_i, one received byte per request
//   out channel : out_valid_o / out_ready_i with channel_index_o, range_value_o and
//                 last_channel_o; a burst is twelve requests, channels 0 to 11
//   cfg channel : cfg_valid_i / cfg_ready_o with cfg_data_i (frames per publish),
//                 always ready; to be written only while the block is idle, which it does not enforce
// throughput: one byte per cycle while in_ready_o is high; parser state and range
// registers update in the same cycle the byte is taken
// latency: the first result of a burst appears the cycle after the last byte of
// the publishing frame is taken, then one result per cycle while out_ready_i is high
// the burst comes from a snapshot register row, so the next frame streams in while
// it drains; only the last byte of a steady frame is held off (in_ready_o low)
// while an earlier burst has not been fully taken, which sets the worst case rate
// when the receiver stalls
// reset: hunting for the start byte, ranges and counters zero, frames per
// publish three, no burst pending
module ultrasonic_bcd_frame_parser_core
  import ubfp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        rx_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ChanW-1:0]       channel_index_o,
  output logic [RangeW-1:0]      range_value_o,
  output logic                   last_channel_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CountW-1:0] cfg_data_i
);

  sync_mode_e        mode_q, mode_d;
  logic [3:0]        pos_q, pos_d;
  logic              hdr_good_q, hdr_good_d;
  logic [1:0]        group_q, group_d;
  logic [7:0]        pend_hi_q, pend_hi_d;
  logic [CountW-1:0] frame_cnt_q, frame_cnt_d;
  logic [CountW-1:0] fpp_q;
  range_t            ranges_q [NumChannels];
  range_t            ranges_d [NumChannels];
  range_t            snap_q   [NumChannels];
  logic              busy_q;
  logic [ChanW-1:0]  out_idx_q;

  logic              in_acc;
  logic              out_acc;
  logic              publish;
  logic [ChanW-1:0]  wr_ch;
  logic              wr_en;
  logic [CountW-1:0] cnt_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !(busy_q && mode_q == SYNC_STEADY && pos_q == PosLast);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = busy_q && out_ready_i;

  assign out_valid_o     = busy_q;
  assign channel_index_o = out_idx_q;
  assign range_value_o   = snap_q[0];
  assign last_channel_o  = (out_idx_q == ChanW'(NumChannels - 1));

  // channel written at the low byte of each pair
  assign wr_ch   = ChanW'({group_q, pos_q[2:1]});
  assign cnt_inc = frame_cnt_q + CountW'(1);

  always_comb begin
    mode_d      = mode_q;
    pos_d       = pos_q;
    hdr_good_d  = hdr_good_q;
    group_d     = group_q;
    pend_hi_d   = pend_hi_q;
    frame_cnt_d = frame_cnt_q;
    publish     = 1'b0;
    wr_en       = 1'b0;

    if (in_acc) begin
      unique case (mode_q)
        SYNC_FIRST, SYNC_STEADY: begin
          if (pos_q == PosSync) begin
            hdr_good_d = (rx_byte_i == SyncByte);
          end else if (pos_q == PosLen && rx_byte_i != LenByte) begin
            hdr_good_d = 1'b0;
          end else if (pos_q == PosType && rx_byte_i != TypeByte) begin
            hdr_good_d = 1'b0;
          end else if (pos_q == PosGroup) begin
            group_d = (rx_byte_i == GroupLoByte) ? GroupLo :
                      (rx_byte_i == GroupMiByte) ? GroupMi : GroupHi;
          end else if (pos_q[3] && !pos_q[0]) begin
            pend_hi_d = rx_byte_i;
          end else if (pos_q[3] && hdr_good_q) begin
            wr_en = 1'b1;
          end

          if (pos_q != PosLast) begin
            pos_d = pos_q + 4'd1;
          end else if (mode_q == SYNC_FIRST) begin
            pos_d      = PosFirst;
            hdr_good_d = 1'b1;
            if (hdr_good_q) begin
              frame_cnt_d = cnt_inc;
              mode_d      = SYNC_STEADY;
              pos_d       = PosSync;
            end
          end else begin
            pos_d = PosSync;
            if (hdr_good_q) begin
              frame_cnt_d = cnt_inc;
              if (cnt_inc >= fpp_q) begin
                frame_cnt_d = '0;
                publish     = 1'b1;
              end
            end
          end
        end
        default: begin
          mode_d = SYNC_HUNT;
          if (rx_byte_i == SyncByte) begin
            mode_d     = SYNC_FIRST;
            pos_d      = PosFirst;
            hdr_good_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NumChannels; k++) begin
      ranges_d[k] = ranges_q[k];
      if (wr_en && wr_ch == ChanW'(k)) begin
        ranges_d[k] = range_calc(pend_hi_q, rx_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= SYNC_HUNT;
      pos_q       <= PosSync;
      hdr_good_q  <= 1'b1;
      group_q     <= GroupLo;
      pend_hi_q   <= '0;
      frame_cnt_q <= '0;
      fpp_q       <= FpuReset;
      busy_q      <= 1'b0;
      out_idx_q   <= '0;
      for (int k = 0; k < NumChannels; k++) begin
        ranges_q[k] <= '0;
      end
    end else begin
      mode_q      <= mode_d;
      pos_q       <= pos_d;
      hdr_good_q  <= hdr_good_d;
      group_q     <= group_d;
      pend_hi_q   <= pend_hi_d;
      frame_cnt_q <= frame_cnt_d;
      ranges_q    <= ranges_d;
      if (cfg_valid_i) begin
        fpp_q <= cfg_data_i;
      end
      if (publish) begin
        busy_q    <= 1'b1;
        out_idx_q <= '0;
      end else if (out_acc) begin
        out_idx_q <= out_idx_q + ChanW'(1);
        if (last_channel_o) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // snapshot row, drained by shifting towards entry zero
  always_ff @(posedge clk_i) begin
    if (publish) begin
      snap_q <= ranges_d;
    end else if (out_acc) begin
      for (int k = 0; k < NumChannels - 1; k++) begin
        snap_q[k] <= snap_q[k+1];
      end
    end
  end

endmodule

`default_nettype wire

// File: dv/ultrasonic_bcd_frame_parser_core_chk.sv
// checker for the ultrasonic bcd frame parser: tracks the byte stream, predicts the
// twelve-channel range bursts and compares each result request in order
// depends on ubfp_pkg
`timescale 1ns / 1ps

module ultrasonic_bcd_frame_parser_core_chk
  import ubfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [ChanW-1:0]  channel_index_i,
  input  logic [RangeW-1:0] range_value_i,
  input  logic              last_channel_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CountW-1:0] cfg_data_i,
  output int                errors_o,
  output int                pending_o
);

  localparam logic [3:0] FirstRangePos = 4'd8;
  localparam logic [3:0] FirstLowPos   = 4'd9;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    range_t           range_val;
    logic             last;
  } reading_t;

  sync_mode_e        mode;
  logic [3:0]        pos;
  logic              hdr_ok;
  logic [1:0]        grp;
  logic [7:0]        hi_byte;
  range_t            ranges [NumChannels];
  logic [CountW-1:0] frame_cnt;
  logic [CountW-1:0] publish_every;
  reading_t          burst_q [$];
  reading_t          want;
  int                fails;

  function automatic int bcd_to_bin(input logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic void track_byte(input logic [7:0] b);
    logic [3:0] p;
    int         ch;
    p = pos;
    if (mode != SYNC_FIRST && mode != SYNC_STEADY) begin
      mode = SYNC_HUNT;
      if (b == SyncByte) begin
        mode   = SYNC_FIRST;
        pos    = PosFirst;
        hdr_ok = 1'b1;
      end
      return;
    end

    if (p == PosSync) begin
      hdr_ok = (b == SyncByte);
    end else if (p == PosLen && b != LenByte) begin
      hdr_ok = 1'b0;
    end else if (p == PosType && b != TypeByte) begin
      hdr_ok = 1'b0;
    end else if (p == PosGroup) begin
      grp = (b == GroupLoByte) ? GroupLo : ((b == GroupMiByte) ? GroupMi : GroupHi);
    end else if (p >= FirstRangePos && !p[0]) begin
      hi_byte = b;
    end else if (p >= FirstLowPos && hdr_ok) begin
      ch = int'(grp) * 4 + int'(p - FirstLowPos) / 2;
      if (ch < NumChannels) ranges[ch] = range_t'(bcd_to_bin(hi_byte) * 100 + bcd_to_bin(b));
    end

    if (p != PosLast) begin
      pos = p + 4'd1;
      return;
    end

    // first frame after the start byte: counts but never publishes
    if (mode == SYNC_FIRST) begin
      pos = PosFirst;
      if (hdr_ok) begin
        frame_cnt = frame_cnt + 1'b1;
        mode      = SYNC_STEADY;
        pos       = PosSync;
      end
      hdr_ok = 1'b1;
      return;
    end

    pos = PosSync;
    if (hdr_ok) begin
      frame_cnt = frame_cnt + 1'b1;
      if (frame_cnt >= publish_every) begin
        frame_cnt = '0;
        for (int k = 0; k < NumChannels; k++) begin
          burst_q.push_back('{chan: ChanW'(k), range_val: ranges[k],
                              last: (k == NumChannels - 1)});
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode          = SYNC_HUNT;
      pos           = PosSync;
      hdr_ok        = 1'b1;
      grp           = GroupLo;
      hi_byte       = '0;
      frame_cnt     = '0;
      publish_every = FpuReset;
      for (int k = 0; k < NumChannels; k++) ranges[k] = '0;
      burst_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (burst_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, actual channel %0d range %0d last %0d",
                   $time, channel_index_i, range_value_i, last_channel_i);
        end else begin
          want = burst_q.pop_front();
          if (channel_index_i !== want.chan) begin
            fails++;
            $display("%0t: channel_index expected %0d actual %0d",
                     $time, want.chan, channel_index_i);
          end
          if (range_value_i !== want.range_val) begin
            fails++;
            $display("%0t: range_value (channel %0d) expected %0d actual %0d",
                     $time, want.chan, want.range_val, range_value_i);
          end
          if (last_channel_i !== want.last) begin
            fails++;
            $display("%0t: last_channel (channel %0d) expected %0d actual %0d",
                     $time, want.chan, want.last, last_channel_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) publish_every = cfg_data_i;
      if (in_valid_i && in_ready_i) track_byte(rx_byte_i);
    end
    errors_o  <= fails;
    pending_o <= burst_q.size();
  end

endmodule

// File: dv/ultrasonic_bcd_frame_parser_core_tb.sv
// testbench top for the ultrasonic bcd frame parser: drives byte frames and
// configuration, random idling on both sides; checking lives in the _chk module
// depends on ubfp_pkg, ultrasonic_bcd_frame_parser_core and its checker
`timescale 1ns / 1ps

module ultrasonic_bcd_frame_parser_core_tb;
  import ubfp_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef logic [7:0] frame_t [16];

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [7:0]        rx_byte_i   = '0;
  logic              out_ready_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic [CountW-1:0] cfg_data_i  = '0;

  logic              in_ready_o;
  logic              out_valid_o;
  logic [ChanW-1:0]  channel_index_o;
  logic [RangeW-1:0] range_value_o;
  logic              last_channel_o;
  logic              cfg_ready_o;

  int          errors;
  int          pending;
  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          bursts_seen = 0;
  int unsigned cycle_cnt   = 0;
  frame_t      f;

  ultrasonic_bcd_frame_parser_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .channel_index_o(channel_index_o),
    .range_value_o  (range_value_o),
    .last_channel_o (last_channel_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  ultrasonic_bcd_frame_parser_core_chk u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .channel_index_i(channel_index_o),
    .range_value_i  (range_value_o),
    .last_channel_i (last_channel_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if (out_valid_o && out_ready_i && last_channel_o) bursts_seen <= bursts_seen + 1;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // valid stays high between back-to-back requests; it only drops on an idle cycle
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_frame(input frame_t fr, input int from);
    for (int k = from; k < 16; k++) send_byte(fr[k]);
  endtask

  // pending is registered, hence the first wait
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_publish_every(input logic [CountW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic frame_t build_frame(input logic [7:0] group_b, input logic [63:0] pairs);
    frame_t fr;
    for (int k = 0; k < 16; k++) fr[k] = 8'($urandom);
    fr[PosSync]  = SyncByte;
    fr[PosLen]   = LenByte;
    fr[PosType]  = TypeByte;
    fr[PosGroup] = group_b;
    for (int k = 0; k < 8; k++) fr[8 + k] = pairs[63 - 8 * k -: 8];
    return fr;
  endfunction

  // mostly well-formed frames with bcd ranges, some with a broken header, some noise
  function automatic frame_t random_frame();
    frame_t fr;
    int     kind;
    kind = $urandom_range(99);
    for (int k = 0; k < 16; k++) fr[k] = 8'($urandom);
    if (kind < 90) begin
      fr[PosSync] = SyncByte;
      fr[PosLen]  = LenByte;
      fr[PosType] = TypeByte;
      case ($urandom_range(2))
        0: fr[PosGroup] = GroupLoByte;
        1: fr[PosGroup] = GroupMiByte;
        default: ;
      endcase
      for (int k = 8; k < 16; k++) begin
        if ($urandom_range(3) != 0) fr[k] = {4'($urandom_range(9)), 4'($urandom_range(9))};
      end
      if (kind >= 75) begin
        case ($urandom_range(2))
          0: fr[PosSync] = fr[PosSync] ^ 8'($urandom_range(1, 255));
          1: fr[PosLen]  = fr[PosLen] ^ 8'($urandom_range(1, 255));
          default: fr[PosType] = fr[PosType] ^ 8'($urandom_range(1, 255));
        endcase
      end
    end
    return fr;
  endfunction

  task automatic run_phase(input logic [CountW-1:0] every, input int s_idle, input int r_stall,
                           input int n_frames, input int pause_after, input int min_bursts);
    int     k;
    frame_t fr;
    wait_idle();
    write_publish_every(every);
    idle_pct  = s_idle;
    stall_pct = r_stall;
    k = 0;
    while (k < n_frames || bursts_seen < min_bursts) begin
      fr = random_frame();
      send_frame(fr, 0);
      if (k == pause_after) wait_idle();
      k++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hunting: noise before the start byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAB);
    send_byte(SyncByte);
    // first frame with a bad length byte, then a retry without a new start byte
    f = build_frame(GroupLoByte, 64'h1111_2222_3333_4444);
    f[PosLen] = 8'h09;
    send_frame(f, 1);
    f = build_frame(GroupLoByte, 64'h9999_0000_FFFF_A53C);
    send_frame(f, 1);
    f = build_frame(GroupMiByte, 64'h1234_5678_9FF9_0110);
    send_frame(f, 0);
    // third valid frame at the reset setting of three: publishes
    f = build_frame(8'hEE, 64'h0001_0999_5A5A_8765);
    send_frame(f, 0);
    f = build_frame(GroupLoByte, 64'h4444_4444_4444_4444);
    f[PosSync] = 8'h55;
    send_frame(f, 0);

    run_phase(4'd15, 65, 0, 1, -1, 0);
    run_phase(4'd0, 0, 65, 2, -1, 0);
    run_phase(4'd1, 8, 8, 1, -1, 0);

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
